// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check that prop holds at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// check that cond never holds outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== sv/cts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counter to system time sync package
// Widths, constants and shared types for the sync core.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int CHANNEL_COUNT_DEF = 2;

  localparam int CH_FIELD_W = 2;
  localparam int CNT_W      = 32;
  localparam int TIME_W     = 64;
  localparam int SLOPE_W    = 48;
  localparam int NUM_W      = CNT_W + TIME_W;     // dividend / shifter width
  localparam int NINE_W     = SLOPE_W + 4;        // 9 * slope
  localparam int SUM_W      = SLOPE_W + 5;        // 9 * slope + sample
  localparam int MCAND_W    = SUM_W;              // multiplicand width
  localparam int STEP_W     = 7;

  localparam logic OP_SYNC    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [SLOPE_W-1:0] SLOPE_ONE = 48'h0001_0000_0000;
  localparam logic [SLOPE_W-1:0] SLOPE_SAT = 48'hFFFF_FFFF_FFFF;
  localparam logic [CNT_W-1:0]   HALF_WRAP = 32'h8000_0000;
  // ceil(2^56 / 10): (x * RECIP_TEN) >> 56 is x / 10 for any x below 2^54
  localparam logic [MCAND_W-1:0] RECIP_TEN = 53'h19_9999_9999_999A;

  localparam logic [STEP_W-1:0] DIV_STEPS_RATIO  = 7'd96;
  localparam logic [STEP_W-1:0] MUL_STEPS_SMOOTH = 7'd56;
  localparam logic [STEP_W-1:0] MUL_STEPS        = 7'd32;

  typedef enum logic {
    AOP_DIV,
    AOP_MUL
  } arith_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV_WAIT,
    ST_SMOOTH_WAIT,
    ST_MUL_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               start;
    arith_op_e          op;
    logic [STEP_W-1:0]  steps;
    logic [NUM_W-1:0]   num;    // dividend MSB aligned, multiplier LSB aligned
    logic [CNT_W-1:0]   den;
    logic [MCAND_W-1:0] mcand;
  } arith_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_sts_t;

  typedef struct packed {
    logic               ready;
    logic [CNT_W-1:0]   last_cnt;
    logic [TIME_W-1:0]  last_sys;
    logic [CNT_W-1:0]   wrap;
    logic [SLOPE_W-1:0] slope;
  } rec_t;

  typedef struct packed {
    logic               pt_we;     // last_cnt, last_sys, ready
    logic               wrap_we;
    logic               slope_we;
    logic [CNT_W-1:0]   last_cnt;
    logic [TIME_W-1:0]  last_sys;
    logic [CNT_W-1:0]   wrap;
    logic [SLOPE_W-1:0] slope;
  } rec_wr_t;

endpackage
`default_nettype wire

// ===== sv/cts_arith.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Shared shift arithmetic unit
// Restoring divider and shift-add multiplier, one bit per cycle. The
// multiplier keeps only the high part: after n steps it holds a * b / 2^n.
// ----------------------------------------------------------------------------
module cts_arith (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cts_pkg::arith_cmd_t           cmd_i,
  output cts_pkg::arith_sts_t           sts_o,
  output logic [cts_pkg::SLOPE_W-1:0]   result_o
);
  import cts_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEP_W-1:0]  step_q, step_d;
  arith_op_e          op_q;
  logic [NUM_W-1:0]   num_q;
  logic [CNT_W-1:0]   den_q;
  logic [CNT_W-1:0]   rem_q;
  logic [SLOPE_W-1:0] quo_q;
  logic               sat_q;
  logic [MCAND_W-1:0] hi_q;
  logic [MCAND_W-1:0] mcand_q;

  logic [CNT_W:0]     rem_ext;
  logic [CNT_W:0]     rem_sub;
  logic               rem_ge;
  logic [MCAND_W:0]   hi_sum;
  logic               load;

  assign load     = cmd_i.start && !busy_q;
  assign rem_ext  = {rem_q, num_q[NUM_W-1]};
  assign rem_ge   = rem_ext >= {1'b0, den_q};
  assign rem_sub  = rem_ext - {1'b0, den_q};
  assign hi_sum   = {1'b0, hi_q} + (num_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (load) begin
      busy_d = 1'b1;
      step_d = cmd_i.steps;
    end else if (busy_q) begin
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q    <= cmd_i.op;
      num_q   <= cmd_i.num;
      den_q   <= cmd_i.den;
      mcand_q <= cmd_i.mcand;
      rem_q   <= '0;
      quo_q   <= '0;
      sat_q   <= 1'b0;
      hi_q    <= '0;
    end else if (busy_q) begin
      if (op_q == AOP_DIV) begin
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        rem_q <= rem_ge ? rem_sub[CNT_W-1:0] : rem_ext[CNT_W-1:0];
        quo_q <= {quo_q[SLOPE_W-2:0], rem_ge};
        // a quotient bit pushed past the top means the ratio is out of range
        sat_q <= sat_q | quo_q[SLOPE_W-1];
      end else begin
        // take multiplier bits LSB first, drop the low product bits
        num_q <= {1'b0, num_q[NUM_W-1:1]};
        hi_q  <= hi_sum[MCAND_W:1];
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign result_o   = (op_q == AOP_DIV) ? (sat_q ? SLOPE_SAT : quo_q)
                                        : hi_q[SLOPE_W-1:0];

  `ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, cmd_i.start && busy_q)
  `ASSERT_PROP(a_rem_below_den, clk_i, rst_ni, (busy_q && op_q == AOP_DIV) |-> (rem_q < den_q))
  `ASSERT_PROP(a_done_ends_run, clk_i, rst_ni, done_q |-> ($past(busy_q) && !busy_q))

endmodule
`default_nettype wire

// ===== sv/cts_rec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Channel sync records
// Per-channel last sync point, wrap count, smoothed slope and ready flag.
// ----------------------------------------------------------------------------
module cts_rec #(
  parameter int CHANNEL_COUNT = cts_pkg::CHANNEL_COUNT_DEF,
  parameter int CH_W          = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CH_W-1:0]  idx_i,
  input  cts_pkg::rec_wr_t wr_i,
  output cts_pkg::rec_t    rec_o
);
  import cts_pkg::*;

  logic               ready_q    [CHANNEL_COUNT];
  logic [CNT_W-1:0]   last_cnt_q [CHANNEL_COUNT];
  logic [TIME_W-1:0]  last_sys_q [CHANNEL_COUNT];
  logic [CNT_W-1:0]   wrap_q     [CHANNEL_COUNT];
  logic [SLOPE_W-1:0] slope_q    [CHANNEL_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        ready_q[i]    <= 1'b0;
        last_cnt_q[i] <= '0;
        last_sys_q[i] <= '0;
        wrap_q[i]     <= '0;
        slope_q[i]    <= SLOPE_ONE;
      end
    end else begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        if (idx_i == CH_W'(i)) begin
          if (wr_i.pt_we) begin
            ready_q[i]    <= 1'b1;
            last_cnt_q[i] <= wr_i.last_cnt;
            last_sys_q[i] <= wr_i.last_sys;
          end
          if (wr_i.wrap_we) begin
            wrap_q[i] <= wr_i.wrap;
          end
          if (wr_i.slope_we) begin
            slope_q[i] <= wr_i.slope;
          end
        end
      end
    end
  end

  assign rec_o.ready    = ready_q[idx_i];
  assign rec_o.last_cnt = last_cnt_q[idx_i];
  assign rec_o.last_sys = last_sys_q[idx_i];
  assign rec_o.wrap     = wrap_q[idx_i];
  assign rec_o.slope    = slope_q[idx_i];

endmodule
`default_nettype wire

// ===== sv/counter_to_system_time_sync_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Counter to system time sync core
// Maps 32-bit timebase counter samples to 64-bit system time per channel.
// ----------------------------------------------------------------------------
// One word at a time passes through a small sequencer around a single shared
// bit-serial divide/multiply unit. A sync word on a ready channel with a
// changed counter runs 96 divide steps for the Q16.32 sample ratio, then 56
// shift-add steps that multiply by a reciprocal of ten for the smoothing
// filter. A convert word on a ready channel runs the 32 multiply steps of the
// slope scaling. Fallback cases, first syncs and syncs with an unchanged
// counter do not use the unit. Input is taken again as soon as the result
// has moved to the output register; a result that cannot move there because
// the output register is still full holds the input.
module counter_to_system_time_sync_core #(
  parameter int CHANNEL_COUNT = cts_pkg::CHANNEL_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // counter_value[31:0], system_time[95:32]
  input  logic [2:0]   s_axis_tuser,   // operation[0], channel[2:1]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // time_out[63:0], slope_out[111:64]
  output logic [0:0]   m_axis_tuser    // used_fallback[0]
);
  import cts_pkg::*;

  localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [3:0] CH_LIMIT = 4'(CHANNEL_COUNT);

  state_e             state_q, state_d;
  logic               op_q;
  logic [CH_FIELD_W-1:0] ch_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [TIME_W-1:0]  now_q;
  logic               neg_q, neg_d;
  logic [NINE_W-1:0]  nine_old_q, nine_old_d;
  logic [TIME_W-1:0]  res_time_q, res_time_d;
  logic               res_fb_q, res_fb_d;
  logic [SLOPE_W-1:0] res_slope_q, res_slope_d;
  logic               out_valid_q, out_valid_d;
  logic [TIME_W-1:0]  out_time_q, out_time_d;
  logic               out_fb_q, out_fb_d;
  logic [SLOPE_W-1:0] out_slope_q, out_slope_d;

  rec_t               rec;
  rec_wr_t            rec_wr;
  arith_cmd_t         arith_cmd;
  arith_sts_t         arith_sts;
  logic [SLOPE_W-1:0] arith_res;

  logic               accept;
  logic               ch_valid;
  logic [CNT_W-1:0]   fwd, bwd;
  logic               wrapped, gt_far, lt_far, neg;
  logic [TIME_W-1:0]  dsys;
  logic [SUM_W-1:0]   smooth_sum;
  logic [TIME_W-1:0]  scaled;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign ch_valid = {2'b00, ch_q} < CH_LIMIT;

  cts_rec #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .CH_W          (CH_W)
  ) u_rec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (CH_W'(ch_q)),
    .wr_i   (rec_wr),
    .rec_o  (rec)
  );

  cts_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (arith_cmd),
    .sts_o    (arith_sts),
    .result_o (arith_res)
  );

  // counter delta both ways round the 32-bit circle
  assign fwd     = cnt_q - rec.last_cnt;
  assign bwd     = rec.last_cnt - cnt_q;
  assign wrapped = cnt_q < rec.last_cnt;
  assign gt_far  = (cnt_q > rec.last_cnt) && (fwd > HALF_WRAP);
  assign lt_far  = wrapped && (bwd > HALF_WRAP);
  assign neg     = (gt_far && (rec.wrap != '0)) || (wrapped && !lt_far);
  assign dsys    = now_q - rec.last_sys;
  assign smooth_sum = SUM_W'(nine_old_q) + SUM_W'(arith_res);
  assign scaled  = TIME_W'(arith_res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tuser[0];
      ch_q  <= s_axis_tuser[2:1];
      cnt_q <= s_axis_tdata[31:0];
      now_q <= s_axis_tdata[95:32];
    end
    neg_q       <= neg_d;
    nine_old_q  <= nine_old_d;
    res_time_q  <= res_time_d;
    res_fb_q    <= res_fb_d;
    res_slope_q <= res_slope_d;
    out_time_q  <= out_time_d;
    out_fb_q    <= out_fb_d;
    out_slope_q <= out_slope_d;
  end

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    nine_old_d  = nine_old_q;
    res_time_d  = res_time_q;
    res_fb_d    = res_fb_q;
    res_slope_d = res_slope_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_time_d  = out_time_q;
    out_fb_d    = out_fb_q;
    out_slope_d = out_slope_q;

    rec_wr          = '0;
    rec_wr.last_cnt = cnt_q;
    rec_wr.last_sys = now_q;
    rec_wr.wrap     = rec.wrap + 1'b1;
    rec_wr.slope    = arith_res;

    arith_cmd       = '0;
    arith_cmd.op    = AOP_DIV;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        res_time_d  = now_q;
        res_fb_d    = 1'b1;
        res_slope_d = rec.slope;
        nine_old_d  = NINE_W'({rec.slope, 3'b000}) + NINE_W'(rec.slope);
        neg_d       = neg;
        state_d     = ST_DONE;
        if (!ch_valid) begin
          res_slope_d = '0;
        end else if (op_q == OP_SYNC) begin
          res_fb_d      = 1'b0;
          rec_wr.pt_we  = 1'b1;
          if (rec.ready) begin
            rec_wr.wrap_we = wrapped;
            if (fwd != '0) begin
              // sample ratio dsys / dcnt in Q16.32
              arith_cmd.start = 1'b1;
              arith_cmd.op    = AOP_DIV;
              arith_cmd.steps = DIV_STEPS_RATIO;
              arith_cmd.num   = {dsys, CNT_W'(0)};
              arith_cmd.den   = fwd;
              state_d         = ST_DIV_WAIT;
            end
          end
        end else if (rec.ready) begin
          arith_cmd.start = 1'b1;
          arith_cmd.op    = AOP_MUL;
          arith_cmd.steps = MUL_STEPS;
          arith_cmd.num   = NUM_W'(neg ? bwd : fwd);
          arith_cmd.mcand = MCAND_W'(rec.slope);
          state_d         = ST_MUL_WAIT;
        end
      end

      ST_DIV_WAIT: begin
        if (arith_sts.done) begin
          // smoothed = (9 * old + sample) / 10, by the reciprocal of ten
          arith_cmd.start = 1'b1;
          arith_cmd.op    = AOP_MUL;
          arith_cmd.steps = MUL_STEPS_SMOOTH;
          arith_cmd.num   = NUM_W'(smooth_sum);
          arith_cmd.mcand = RECIP_TEN;
          state_d         = ST_SMOOTH_WAIT;
        end
      end

      ST_SMOOTH_WAIT: begin
        if (arith_sts.done) begin
          rec_wr.slope_we = 1'b1;
          res_slope_d     = arith_res;
          state_d         = ST_DONE;
        end
      end

      ST_MUL_WAIT: begin
        if (arith_sts.done) begin
          res_time_d = neg_q ? (rec.last_sys - scaled) : (rec.last_sys + scaled);
          res_fb_d   = 1'b0;
          state_d    = ST_DONE;
        end
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_time_d  = res_time_q;
          out_fb_d    = res_fb_q;
          out_slope_d = res_slope_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready   = (state_q == ST_IDLE);
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {out_slope_q, out_time_q};
  assign m_axis_tuser[0] = out_fb_q;

  `ASSERT_PROP(a_accept_unit_idle, clk_i, rst_ni, accept |-> !arith_sts.busy)
  `ASSERT_PROP(a_done_holds, clk_i, rst_ni, (state_q == ST_DONE && out_valid_q && !m_axis_tready) |=> (state_q == ST_DONE && out_valid_q))
  `ASSERT_PROP(a_unit_done_in_wait, clk_i, rst_ni, arith_sts.done |-> (state_q == ST_DIV_WAIT || state_q == ST_SMOOTH_WAIT || state_q == ST_MUL_WAIT))

endmodule
`default_nettype wire
